// File: design/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg: shared definitions for the indexed list insert/delete unit
// Build constants, command and status codes, and the control bundle that the
// sequencer broadcasts to every list cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_REVERSE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [CNT_W-1:0]     pos;
    logic [WORD_BITS-1:0] word;
  } cell_ctrl_t;

endpackage

// File: design/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell: one entry of the list
// Holds one word and, each cycle, keeps it, takes a neighbor's word or takes
// the broadcast word, as the shared control bundle tells it.
// ----------------------------------------------------------------------------
module ilid_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk,
  input  ilid_pkg::cell_ctrl_t          ctrl,
  input  logic [ilid_pkg::WORD_BITS-1:0] lower_word,
  input  logic [ilid_pkg::WORD_BITS-1:0] upper_word,
  output logic [ilid_pkg::WORD_BITS-1:0] value,
  output logic [ilid_pkg::WORD_BITS-1:0] tap
);
  import ilid_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  logic [WORD_BITS-1:0] value_next;

  // The selected cell shows its word for a delete; all others show zero.
  assign tap = (MY_POS == ctrl.pos) ? value : '0;

  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (MY_POS == ctrl.pos) begin
          value_next = ctrl.word;
        end else if (MY_POS > ctrl.pos) begin
          value_next = lower_word;
        end
      end
      OP_DELETE: begin
        if (MY_POS >= ctrl.pos) begin
          value_next = upper_word;
        end
      end
      // The front word moves to the bound; cells below it close the gap.
      OP_ROTATE: begin
        if (MY_POS == ctrl.pos) begin
          value_next = ctrl.word;
        end else if (MY_POS < ctrl.pos) begin
          value_next = upper_word;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: design/indexed_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit: ordered word list with insert, delete and
// reverse
// Top level: command sequencer, capacity register and the row of list cells.
// ----------------------------------------------------------------------------
// The list lives in a row of 16 cells of 32 bits, one per position; every
// cell decides on its own each cycle whether to keep its word, take a
// neighbor's or take a broadcast word. Insert and delete finish in the cycle
// the item is accepted, so their result is ready in the next cycle. Reverse
// of a list of n entries runs n-1 rotation steps (none for n below two): each
// step lifts the front word out and drops it at a bound that moves down by
// one, while the cells below the bound shift down. One item is in work at a
// time; a new item is taken once the previous result has left or is leaving
// the output register. The capacity register resets to 16; a value of zero
// acts as one and a value above 16 acts as 16. It may be written only while
// the block is idle. Entries at or above the count hold undefined data and
// are never returned.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ilid_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [4:0]                     position,
  input  logic [31:0]                    word_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [31:0]                    removed_word,
  output logic [4:0]                     count
);
  import ilid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_REV  = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     held_count, held_count_next;
  logic [CNT_W-1:0]     capacity, eff_capacity;
  logic [CNT_W-1:0]     rev_bound, rev_bound_next;
  logic                 accept;
  logic                 result_load;
  logic [1:0]           result_status;
  logic [WORD_BITS-1:0] result_word;
  cell_ctrl_t           ctrl;

  logic [WORD_BITS-1:0] cell_value [DEPTH];
  logic [WORD_BITS-1:0] cell_tap   [DEPTH];
  logic [WORD_BITS-1:0] lower_word [DEPTH];
  logic [WORD_BITS-1:0] upper_word [DEPTH];
  logic [WORD_BITS-1:0] tap_or;

  // A new item enters only when idle and the output register is free.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Capacity is clamped to the range the row of cells can hold.
  always_comb begin
    if (capacity == '0) begin
      eff_capacity = CNT_W'(1);
    end else if (capacity > CNT_W'(DEPTH)) begin
      eff_capacity = CNT_W'(DEPTH);
    end else begin
      eff_capacity = capacity;
    end
  end

  // The word being deleted is gathered from the one cell that matches.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    rev_bound_next  = rev_bound;
    result_load     = 1'b0;
    result_status   = ST_OK;
    result_word     = '0;
    ctrl.op         = OP_HOLD;
    ctrl.pos        = CNT_W'(position);
    ctrl.word       = word_in[WORD_BITS-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          result_load = 1'b1;
          unique case (cmd)
            CMD_INSERT: begin
              if (held_count >= eff_capacity) begin
                result_status = ST_FULL;
              end else if (CNT_W'(position) > held_count) begin
                result_status = ST_RANGE;
              end else begin
                ctrl.op         = OP_INSERT;
                held_count_next = held_count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (held_count == '0) begin
                result_status = ST_EMPTY;
              end else if (CNT_W'(position) >= held_count) begin
                result_status = ST_RANGE;
              end else begin
                ctrl.op         = OP_DELETE;
                result_word     = tap_or;
                held_count_next = held_count - CNT_W'(1);
              end
            end
            CMD_REVERSE: begin
              // Lists of two or more entries take the rotation sequence and
              // report once it ends.
              if (held_count >= CNT_W'(2)) begin
                result_load    = 1'b0;
                rev_bound_next = held_count - CNT_W'(1);
                state_next     = S_REV;
              end
            end
            default: begin
              result_status = ST_OK;
            end
          endcase
        end
      end
      S_REV: begin
        ctrl.op        = OP_ROTATE;
        ctrl.pos       = rev_bound;
        ctrl.word      = cell_value[0];
        rev_bound_next = rev_bound - CNT_W'(1);
        if (rev_bound == CNT_W'(1)) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Row of cells; the ends see the broadcast word and their own word.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lower_word[g] = ctrl.word;
    end else begin : g_mid_lo
      assign lower_word[g] = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper_word[g] = cell_value[g];
    end else begin : g_mid_hi
      assign upper_word[g] = cell_value[g+1];
    end

    ilid_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .lower_word (lower_word[g]),
      .upper_word (upper_word[g]),
      .value      (cell_value[g]),
      .tap        (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      capacity   <= CNT_W'(16);
      rev_bound  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      rev_bound  <= rev_bound_next;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; held while the item waits at the output.
  always_ff @(posedge clk) begin
    if (result_load) begin
      status       <= result_status;
      removed_word <= 32'(result_word);
      count        <= 5'(held_count_next);
    end
  end

endmodule
